/* rtl/cfdlw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdlw_pkg
// Shared types and constants for the frame deframer with link watchdog.
// ----------------------------------------------------------------------------
package cfdlw_pkg;

  localparam int BUF_DEPTH = 1024;
  localparam int BAW       = $clog2(BUF_DEPTH);      // byte store address
  localparam int FCW       = $clog2(BUF_DEPTH + 1);  // fill count, prefix address
  localparam int TW        = 17;                     // tick counter / timeouts
  localparam int CFG_IW    = 2;

  localparam logic [7:0]    MARK_START = 8'hFF;
  localparam logic [7:0]    MARK_END   = 8'hFE;
  localparam logic [15:0]   MIN_LEN    = 16'd7;
  localparam logic [15:0]   CTRL_LEN   = 16'd8;
  localparam logic [TW-1:0] TICK_MAX   = {TW{1'b1}};
  localparam logic [7:0]    HID_FWD    = 8'h01;
  localparam logic [7:0]    HID_CTRL   = 8'h02;
  localparam logic [7:0]    CID_KEEP   = 8'h01;
  localparam logic [7:0]    CID_REBOOT = 8'h02;

  localparam logic [TW-1:0] INIT_TMO_RST = 17'd120000;
  localparam logic [TW-1:0] KEEP_TMO_RST = 17'd60000;

  localparam logic [CFG_IW-1:0] CFG_INIT_TMO = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_KEEP_TMO = 2'd1;

  localparam logic [1:0] MODE_INITIAL = 2'd0;
  localparam logic [1:0] MODE_ACTIVE  = 2'd1;
  localparam logic [1:0] MODE_ERROR   = 2'd2;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_FORWARD  = 3'd1;
  localparam logic [2:0] ACT_KEEP     = 3'd2;
  localparam logic [2:0] ACT_REBOOT   = 3'd3;
  localparam logic [2:0] ACT_BAD_SIZE = 3'd4;
  localparam logic [2:0] ACT_UNK_CMD  = 3'd5;
  localparam logic [2:0] ACT_UNK_HID  = 3'd6;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_found;
    logic [7:0]  handler_id;
    logic [7:0]  command_id;
    logic [10:0] frame_length;
    logic [2:0]  action;
    logic [1:0]  link_state;
    logic        timed_out;
  } out_item_t;

  typedef struct packed {
    logic       is_tick;
    logic       is_end;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic [TW-1:0] init_tmo;
    logic [TW-1:0] keep_tmo;
  } cfg_t;

endpackage

/* rtl/checksummed_frame_deframer_link_watchdog.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_link_watchdog
// Byte-stream deframer (start, length, checksum, end) with link watchdog.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): each transaction is a received
// byte or a one-millisecond tick. Result channel (out_valid/out_stall/
// out_data): exactly one result per input transaction, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
// initial timeout, index 1 the keepalive timeout; cfg_ready is always high.
// A two-entry queue sits between the input side and the execution side.
// Ticks, bytes in error state and bytes that are not an end marker pass from
// the queue through the result register into the output register, and the
// engine takes the next item only once that result is in the output register.
// An end marker scans start positions through the byte and prefix-sum RAM
// read ports, one position per cycle, stopping at the first match.
// Reset: empty store, link INITIAL, timeouts at their defaults, no clearing
// pass. When the receiver stalls, the held result stays put, the engine
// finishes the next item and waits, and the queue fills before in_stall rises.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_link_watchdog
  import cfdlw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [TW-1:0]     cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    q_valid, q_pop;
  q_item_t q_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INIT_TMO) cfg_nxt.init_tmo = cfg_data;
      if (cfg_index == CFG_KEEP_TMO) cfg_nxt.keep_tmo = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_tmo <= INIT_TMO_RST;
      cfg_r.keep_tmo <= KEEP_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfdlw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  cfdlw_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

/* rtl/cfdlw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdlw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfdlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/cfdlw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdlw_front
// Input side: classifies each transaction and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module cfdlw_front
  import cfdlw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_pop
);

  q_item_t    slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_item_t    cls;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    cls.is_tick = in_data.opcode;
    cls.is_end  = !in_data.opcode && (in_data.rx_byte == MARK_END);
    cls.data    = in_data.rx_byte;
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

/* rtl/cfdlw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdlw_back
// Execution side: byte store, prefix sums, frame scan, decode and watchdog.
// ----------------------------------------------------------------------------
module cfdlw_back
  import cfdlw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE_A, ST_PRE_B, ST_PRE_C, ST_SCAN, ST_DONE
  } state_t;

  state_t    state_r, state_nxt;
  logic [FCW-1:0] fill_r, fill_nxt, a_r, a_nxt, rdq_r;
  logic [15:0]    sum_r, sum_nxt, pend_r, pend_nxt, pp_r, pp_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [TW-1:0]  elapsed_r, elapsed_nxt;
  logic [7:0]     wb_r [4];
  logic [7:0]     wb_nxt [4];
  logic [7:0]     chk_hi_r, chk_hi_nxt, chk_lo_r, chk_lo_nxt;
  out_item_t      res_r, res_nxt, out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           we;
  logic [FCW-1:0] fill_eff, rd_addr;
  logic [15:0]    sum_eff, pfx_rdata, pfx_val;
  logic [7:0]     byte_rdata;
  logic [TW-1:0]  el_inc, limit;
  logic [15:0]    len;
  logic [16:0]    s_ext;
  logic           match;
  logic [1:0]     dmode;
  logic [TW-1:0]  delap;
  logic [2:0]     dact;

  cfdlw_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH), .AW(BAW)) u_bytes (
    .clk(clk), .we(we), .waddr(fill_eff[BAW-1:0]), .wdata(q_item.data),
    .raddr(rd_addr[BAW-1:0]), .rdata(byte_rdata)
  );

  // entry zero is never written; reads of it are forced to zero below
  cfdlw_ram #(.WIDTH(16), .DEPTH(BUF_DEPTH + 1), .AW(FCW)) u_pfx (
    .clk(clk), .we(we), .waddr(fill_eff + FCW'(1)), .wdata(sum_eff + 16'(q_item.data)),
    .raddr(rd_addr), .rdata(pfx_rdata)
  );

  assign pfx_val   = (rdq_r == '0) ? 16'd0 : pfx_rdata;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    fill_eff = (fill_r >= FCW'(BUF_DEPTH)) ? '0 : fill_r;
    sum_eff  = (fill_r >= FCW'(BUF_DEPTH)) ? 16'd0 : sum_r;
    el_inc   = (elapsed_r < TICK_MAX) ? elapsed_r + TW'(1) : elapsed_r;
    limit    = (mode_r == MODE_INITIAL) ? cfg.init_tmo : cfg.keep_tmo;

    // candidate start is four bytes behind the byte now arriving
    len   = {wb_r[1], wb_r[2]};
    s_ext = 17'(rdq_r) - 17'd4;
    match = (rdq_r >= FCW'(4)) && (wb_r[0] == MARK_START) && (len >= MIN_LEN) &&
            ((s_ext + 17'(len)) == 17'(fill_r)) &&
            ((pend_r - pp_r) == {chk_hi_r, chk_lo_r});

    // frame decode
    dmode = (mode_r == MODE_INITIAL) ? MODE_ACTIVE : mode_r;
    delap = (mode_r == MODE_INITIAL) ? '0 : elapsed_r;
    priority if (wb_r[3] == HID_FWD) begin
      dact = ACT_FORWARD;
    end else if (wb_r[3] != HID_CTRL) begin
      dact = ACT_UNK_HID;
    end else if (byte_rdata == CID_KEEP || byte_rdata == CID_REBOOT) begin
      if (len != CTRL_LEN) begin
        dact = ACT_BAD_SIZE;
      end else if (byte_rdata == CID_KEEP) begin
        dact  = ACT_KEEP;
        delap = '0;
      end else begin
        dact  = ACT_REBOOT;
        dmode = MODE_INITIAL;
        delap = '0;
      end
    end else begin
      dact = ACT_UNK_CMD;
    end

    state_nxt   = state_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    a_nxt       = a_r;
    pend_nxt    = pend_r;
    pp_nxt      = pp_r;
    chk_hi_nxt  = chk_hi_r;
    chk_lo_nxt  = chk_lo_r;
    wb_nxt      = wb_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop   = 1'b0;
    we      = 1'b0;
    rd_addr = a_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          res_nxt   = '0;
          state_nxt = ST_DONE;
          if (q_item.is_tick) begin
            if (mode_r != MODE_ERROR) begin
              elapsed_nxt = el_inc;
              if (el_inc > limit) begin
                mode_nxt          = MODE_ERROR;
                res_nxt.timed_out = 1'b1;
              end
            end
          end else if (mode_r != MODE_ERROR) begin
            we       = 1'b1;
            fill_nxt = fill_eff + FCW'(1);
            sum_nxt  = sum_eff + 16'(q_item.data);
            if (q_item.is_end && (fill_eff + FCW'(1) >= FCW'(MIN_LEN))) begin
              state_nxt = ST_PRE_A;
            end
          end
          res_nxt.link_state = mode_nxt;
        end
      end
      ST_PRE_A: begin
        rd_addr   = fill_r - FCW'(3);
        state_nxt = ST_PRE_B;
      end
      ST_PRE_B: begin
        rd_addr    = fill_r - FCW'(2);
        chk_hi_nxt = byte_rdata;
        pend_nxt   = pfx_val;
        state_nxt  = ST_PRE_C;
      end
      ST_PRE_C: begin
        chk_lo_nxt = byte_rdata;
        rd_addr    = '0;
        a_nxt      = FCW'(1);
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        rd_addr = a_r;
        a_nxt   = a_r + FCW'(1);
        wb_nxt[0] = wb_r[1];
        wb_nxt[1] = wb_r[2];
        wb_nxt[2] = wb_r[3];
        wb_nxt[3] = byte_rdata;
        pp_nxt    = pfx_val;
        if (match) begin
          res_nxt.frame_found  = 1'b1;
          res_nxt.handler_id   = wb_r[3];
          res_nxt.command_id   = byte_rdata;
          res_nxt.frame_length = len[10:0];
          res_nxt.action       = dact;
          res_nxt.link_state   = dmode;
          mode_nxt    = dmode;
          elapsed_nxt = delap;
          fill_nxt    = '0;
          sum_nxt     = 16'd0;
          state_nxt   = ST_DONE;
        end else if (rdq_r == fill_r - FCW'(3)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      sum_r       <= 16'd0;
      mode_r      <= MODE_INITIAL;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      mode_r      <= mode_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r      <= a_nxt;
    rdq_r    <= rd_addr;
    pend_r   <= pend_nxt;
    pp_r     <= pp_nxt;
    chk_hi_r <= chk_hi_nxt;
    chk_lo_r <= chk_lo_nxt;
    wb_r     <= wb_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule

/* rtl/cfdlw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdlw_props
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cfdlw_props
  import cfdlw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_found |->
      out_data.frame_length == 11'd0 && out_data.action == ACT_NONE &&
      out_data.handler_id == 8'd0 && out_data.command_id == 8'd0)
    else $error("frame fields set without a frame");

  a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timed_out |->
      out_data.link_state == MODE_ERROR && !out_data.frame_found)
    else $error("timeout without error state");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_found |->
      out_data.frame_length >= 11'd7 && out_data.action != ACT_NONE &&
      out_data.link_state != MODE_ERROR)
    else $error("bad accepted frame");

endmodule

bind checksummed_frame_deframer_link_watchdog cfdlw_props u_cfdlw_checker (.*);

/* tb/cfdlw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdlw_checker
// Watches the input, result and register channels of the deframer, keeps its
// own model of the byte store and link watchdog, and compares each result
// transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module cfdlw_checker
  import cfdlw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [TW-1:0]     cfg_data,
  output int                mismatches,
  output int                pending
);

  logic [7:0]     rx_bytes [BUF_DEPTH];
  logic [15:0]    running_sum [BUF_DEPTH + 1];
  int unsigned    fill;
  logic [1:0]     mode;
  logic [TW-1:0]  ticks;
  logic [TW-1:0]  init_limit;
  logic [TW-1:0]  keep_limit;
  out_item_t      expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [2:0] decode_action(logic [7:0] hid, logic [7:0] cid,
                                               logic [15:0] len);
    if (mode == MODE_INITIAL) begin
      mode  = MODE_ACTIVE;
      ticks = '0;
    end
    if (hid == HID_FWD) return ACT_FORWARD;
    if (hid != HID_CTRL) return ACT_UNK_HID;
    if (cid == CID_KEEP) begin
      if (len != CTRL_LEN) return ACT_BAD_SIZE;
      ticks = '0;
      return ACT_KEEP;
    end
    if (cid == CID_REBOOT) begin
      if (len != CTRL_LEN) return ACT_BAD_SIZE;
      mode  = MODE_INITIAL;
      ticks = '0;
      return ACT_REBOOT;
    end
    return ACT_UNK_CMD;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t      r;
    logic [TW-1:0]  lim;
    logic [15:0]    len;
    logic [15:0]    calc;
    logic [15:0]    pkt;
    r = '0;
    if (it.opcode) begin
      if (mode != MODE_ERROR) begin
        lim = (mode == MODE_INITIAL) ? init_limit : keep_limit;
        if (ticks != TICK_MAX) ticks = ticks + 1'b1;
        if (ticks > lim) begin
          mode = MODE_ERROR;
          r.timed_out = 1'b1;
        end
      end
    end else if (mode != MODE_ERROR) begin
      if (fill >= BUF_DEPTH) fill = 0;
      rx_bytes[fill]        = it.rx_byte;
      running_sum[fill + 1] = running_sum[fill] + 16'(it.rx_byte);
      fill++;
      if (it.rx_byte == MARK_END) begin
        for (int unsigned s = 0; s + 7 <= fill; s++) begin
          if (rx_bytes[s] != MARK_START) continue;
          len = {rx_bytes[s + 1], rx_bytes[s + 2]};
          if (len < MIN_LEN || s + len != fill) continue;
          calc = running_sum[fill - 3] - running_sum[s + 3];
          pkt  = {rx_bytes[fill - 3], rx_bytes[fill - 2]};
          if (calc != pkt) continue;
          r.frame_found  = 1'b1;
          r.handler_id   = rx_bytes[s + 3];
          r.command_id   = rx_bytes[s + 4];
          r.frame_length = len[10:0];
          r.action       = decode_action(rx_bytes[s + 3], rx_bytes[s + 4], len);
          fill = 0;
          break;
        end
      end
    end
    r.link_state = mode;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fill        = 0;
      mode        = MODE_INITIAL;
      ticks       = '0;
      init_limit  = INIT_TMO_RST;
      keep_limit  = KEEP_TMO_RST;
      running_sum[0] = '0;
      mismatches  = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result transaction %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want.frame_found !== out_data.frame_found ||
              want.handler_id !== out_data.handler_id ||
              want.command_id !== out_data.command_id ||
              want.frame_length !== out_data.frame_length ||
              want.action !== out_data.action ||
              want.link_state !== out_data.link_state ||
              want.timed_out !== out_data.timed_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result mismatch at %0t\n  expected %p\n  actual   %p",
                       $realtime, want, out_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_INIT_TMO) init_limit = cfg_data;
        else if (cfg_index == CFG_KEEP_TMO) keep_limit = cfg_data;
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(in_data));
    end
  end

endmodule

/* tb/checksummed_frame_deframer_link_watchdog_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_link_watchdog_tb
// Drives byte and tick transactions into the deframer: directed frames, then
// random well-formed, corrupted and noise traffic under several timeout
// settings, ending with the link driven into its error state.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_link_watchdog_tb;
  import cfdlw_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [TW-1:0]     cfg_data = '0;
  int                mismatches;
  int                pending;
  bit                calm = 1'b0;
  int                hold_left = 0;

  always #2 clk = ~clk;

  checksummed_frame_deframer_link_watchdog uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cfdlw_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches,
    .pending
  );

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(input logic op, input logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, rx_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] body[$], input bit corrupt);
    logic [7:0]  bytes[$];
    logic [15:0] sum;
    logic [15:0] len;
    int          pos;
    sum = '0;
    foreach (body[i]) sum += 16'(body[i]);
    len = 16'(body.size() + 6);
    bytes = {MARK_START, len[15:8], len[7:0]};
    bytes = {bytes, body, sum[15:8], sum[7:0], MARK_END};
    if (corrupt) begin
      pos = $urandom_range(0, bytes.size() - 1);
      bytes[pos] = 8'($urandom_range(0, 255));
    end
    foreach (bytes[i]) send(1'b0, bytes[i]);
  endtask

  task automatic random_frame();
    logic [7:0] body[$];
    int         n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 2;
    for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    case ($urandom_range(0, 3))
      0: body[0] = HID_FWD;
      1, 2: body[0] = HID_CTRL;
      default: ;
    endcase
    if (n > 1 && $urandom_range(0, 3) != 0)
      body[1] = $urandom_range(0, 1) ? CID_KEEP : CID_REBOOT;
    send_frame(body, $urandom_range(0, 6) == 0);
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        random_frame();
        sent += 8;
      end else if (r < 82) begin
        n = $urandom_range(1, 6);
        repeat (n) send(1'b0, 8'($urandom));
        sent += n;
      end else begin
        send(1'b1, 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [TW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("FAIL checksummed_frame_deframer_link_watchdog");
    $finish;
  end

  initial begin
    logic [7:0] keep_body[$];
    logic [7:0] min_body[$];
    logic [7:0] short_frame[$];
    keep_body   = {HID_CTRL, CID_KEEP};
    min_body    = {8'h00};
    short_frame = {MARK_START, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00, MARK_END};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: keepalive, shortest frame, tick carrying a byte, short length
    send_frame(keep_body, 1'b0);
    send_frame(min_body, 1'b0);
    send(1'b1, 8'hFF);
    foreach (short_frame[i]) send(1'b0, short_frame[i]);
    drain();

    write_reg(CFG_INIT_TMO, {TW{1'b1}});
    write_reg(CFG_KEEP_TMO, {TW{1'b1}});
    random_traffic(180);
    drain();

    write_reg(CFG_INIT_TMO, 17'($urandom_range(40, 1000)));
    write_reg(CFG_KEEP_TMO, 17'($urandom_range(40, 1000)));
    random_traffic(180);
    drain();

    // run the link into error and keep feeding it
    write_reg(CFG_INIT_TMO, '0);
    write_reg(CFG_KEEP_TMO, 17'd3);
    calm = 1'b1;
    random_traffic(140);
    drain();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS checksummed_frame_deframer_link_watchdog");
    else
      $display("FAIL checksummed_frame_deframer_link_watchdog");
    $finish;
  end

endmodule
